>>> hw/rtl/rmq_pkg.sv
package rmq_pkg;

    // number format
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned FW        = 18;
    localparam int          ONE       = 1 << FRAC_BITS;

    // radicand, unsigned after clamping
    localparam int unsigned ARG_W = FW + 1;
    // sum or difference of two entries
    localparam int unsigned VW    = FW + 1;
    // root of the radicand scaled by 2^FRAC_BITS
    localparam int unsigned SW    = (ARG_W + FRAC_BITS + 1) / 2;
    // quotient bits computed by each divider lane
    localparam int unsigned QW    = FW;

    // output limits as unsigned magnitudes
    localparam logic [QW:0] POS_LIM = (QW + 1)'((1 << (FW - 1)) - 1);
    localparam logic [QW:0] NEG_LIM = (QW + 1)'(1 << (FW - 1));

    // queue between front and back
    localparam int unsigned QUEUE_DEPTH_DEF = 2;

    // pipeline depths
    localparam int unsigned SQRT_LAT  = SW;
    localparam int unsigned DIV_LAT   = QW + 2;
    localparam int unsigned TOTAL_LAT = SQRT_LAT + DIV_LAT + 3;

    // which component carries the square root
    typedef enum logic [1:0] {
        PIV_X = 2'd0,
        PIV_Y = 2'd1,
        PIV_Z = 2'd2,
        PIV_W = 2'd3
    } t_pivot;

    // classified request handed from front to back
    typedef struct packed {
        logic [ARG_W-1:0]     arg;
        t_pivot               pivot;
        logic [2:0][VW-1:0]   lane;
    } t_item;

endpackage

>>> hw/rtl/rmq_front.sv
module rmq_front import rmq_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_queue_full,
    input  logic [8:0][FW-1:0] i_mat,
    output logic               o_busy,
    output logic               o_valid,
    output t_item              o_item
);

    localparam int unsigned TW = FW + 2;
    localparam int unsigned PW = FW + 3;

    logic signed [FW-1:0] m [3][3];
    logic signed [TW-1:0] trace;
    logic signed [PW-1:0] piv_arg;
    logic signed [FW-1:0] d_i;
    logic signed [FW-1:0] d_j;
    logic signed [FW-1:0] d_k;
    t_pivot               piv;
    t_item                n_item;
    logic                 r_valid;
    t_item                r_item;
    logic                 push;
    logic                 accept;

    // unpack the matrix
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                m[r][c] = $signed(i_mat[r * 3 + c]);
            end
        end
    end

    // trace, pivot choice and the three quotient operands
    always_comb begin
        trace = TW'(m[0][0]) + TW'(m[1][1]) + TW'(m[2][2]);

        piv = PIV_X;
        if (m[1][1] > m[0][0]) piv = PIV_Y;
        if (m[2][2] > ((piv == PIV_Y) ? m[1][1] : m[0][0])) piv = PIV_Z;

        case (piv)
            PIV_Y: begin
                d_i = m[1][1]; d_j = m[2][2]; d_k = m[0][0];
            end
            PIV_Z: begin
                d_i = m[2][2]; d_j = m[0][0]; d_k = m[1][1];
            end
            default: begin
                d_i = m[0][0]; d_j = m[1][1]; d_k = m[2][2];
            end
        endcase
        piv_arg = PW'(d_i) - PW'(d_j) - PW'(d_k) + PW'(ONE);

        n_item = '0;
        if (trace > 0) begin
            n_item.pivot   = PIV_W;
            n_item.arg     = ARG_W'(trace + TW'(ONE));
            n_item.lane[0] = VW'(m[2][1]) - VW'(m[1][2]);
            n_item.lane[1] = VW'(m[0][2]) - VW'(m[2][0]);
            n_item.lane[2] = VW'(m[1][0]) - VW'(m[0][1]);
        end else begin
            n_item.pivot = piv;
            n_item.arg   = (piv_arg < 0) ? '0 : ARG_W'(piv_arg);
            case (piv)
                PIV_Y: begin
                    n_item.lane[0] = VW'(m[0][1]) + VW'(m[1][0]);
                    n_item.lane[1] = VW'(m[2][1]) + VW'(m[1][2]);
                    n_item.lane[2] = VW'(m[0][2]) - VW'(m[2][0]);
                end
                PIV_Z: begin
                    n_item.lane[0] = VW'(m[0][2]) + VW'(m[2][0]);
                    n_item.lane[1] = VW'(m[1][2]) + VW'(m[2][1]);
                    n_item.lane[2] = VW'(m[1][0]) - VW'(m[0][1]);
                end
                default: begin
                    n_item.lane[0] = VW'(m[1][0]) + VW'(m[0][1]);
                    n_item.lane[1] = VW'(m[2][0]) + VW'(m[0][2]);
                    n_item.lane[2] = VW'(m[2][1]) - VW'(m[1][2]);
                end
            endcase
        end
    end

    // request handshake
    assign push   = r_valid && !i_queue_full;
    assign o_busy = !i_rst_n || (r_valid && i_queue_full);
    assign accept = i_start && !o_busy;

    // classified request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = push;
    assign o_item  = r_item;

endmodule

>>> hw/rtl/rmq_queue.sv
module rmq_queue import rmq_pkg::*; #(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_full,
    output logic  o_valid,
    output t_item o_item
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              push_ok;
    logic              pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

>>> hw/rtl/rmq_sqrt.sv
module rmq_sqrt import rmq_pkg::*; #(
    parameter int unsigned TAG_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [ARG_W-1:0] i_arg,
    input  logic [TAG_W-1:0] i_tag,
    output logic             o_valid,
    output logic [SW-1:0]    o_root,
    output logic [TAG_W-1:0] o_tag
);

    localparam int unsigned XW = 2 * SW;
    localparam int unsigned RW = SW + 2;

    logic             r_valid [SW];
    logic [RW-1:0]    r_rem   [SW];
    logic [SW-1:0]    r_root  [SW];
    logic [XW-1:0]    r_x     [SW];
    logic [TAG_W-1:0] r_tag   [SW];

    logic             c_valid [SW];
    logic [RW-1:0]    c_rem   [SW];
    logic [SW-1:0]    c_root  [SW];
    logic [XW-1:0]    c_x     [SW];
    logic [TAG_W-1:0] c_tag   [SW];

    logic [RW-1:0]    n_rem   [SW];
    logic [SW-1:0]    n_root  [SW];
    logic [XW-1:0]    n_x     [SW];
    logic [RW+1:0]    rem_sh  [SW];
    logic [RW+1:0]    trial   [SW];

    // stage inputs
    always_comb begin
        c_valid[0] = i_valid;
        c_rem[0]   = '0;
        c_root[0]  = '0;
        c_x[0]     = XW'({i_arg, {FRAC_BITS{1'b0}}});
        c_tag[0]   = i_tag;
        for (int t = 1; t < SW; t++) begin
            c_valid[t] = r_valid[t-1];
            c_rem[t]   = r_rem[t-1];
            c_root[t]  = r_root[t-1];
            c_x[t]     = r_x[t-1];
            c_tag[t]   = r_tag[t-1];
        end
    end

    // one root bit per stage
    always_comb begin
        for (int t = 0; t < SW; t++) begin
            rem_sh[t] = {c_rem[t], c_x[t][XW-1 -: 2]};
            trial[t]  = (RW + 2)'({c_root[t], 2'b01});
            if (rem_sh[t] >= trial[t]) begin
                n_rem[t]  = RW'(rem_sh[t] - trial[t]);
                n_root[t] = {c_root[t][SW-2:0], 1'b1};
            end else begin
                n_rem[t]  = RW'(rem_sh[t]);
                n_root[t] = {c_root[t][SW-2:0], 1'b0};
            end
            n_x[t] = {c_x[t][XW-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < SW; t++) r_valid[t] <= 1'b0;
        end else begin
            for (int t = 0; t < SW; t++) r_valid[t] <= c_valid[t];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < SW; t++) begin
            r_rem[t]  <= n_rem[t];
            r_root[t] <= n_root[t];
            r_x[t]    <= n_x[t];
            r_tag[t]  <= c_tag[t];
        end
    end

    assign o_valid = r_valid[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_tag   = r_tag[SW-1];

endmodule

>>> hw/rtl/rmq_div.sv
module rmq_div import rmq_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic signed [VW-1:0] i_v,
    input  logic [SW-1:0]        i_s,
    output logic                 o_valid,
    output logic signed [FW-1:0] o_q
);

    localparam int unsigned DW = SW + 1;
    localparam int unsigned RW = DW + 1;
    localparam int unsigned CW = SW + 3;
    localparam int unsigned NW = VW + FRAC_BITS;

    logic [VW-1:0]  mag;
    logic [NW-1:0]  num;

    // prepared operands
    logic           r_p_valid;
    logic           r_p_neg;
    logic           r_p_zero;
    logic           r_p_ovf;
    logic [DW-1:0]  r_p_d;
    logic [RW-1:0]  r_p_rem;
    logic [QW-1:0]  r_p_lo;

    // quotient stages
    logic           r_valid [QW];
    logic           r_neg   [QW];
    logic           r_zero  [QW];
    logic           r_ovf   [QW];
    logic [DW-1:0]  r_d     [QW];
    logic [RW-1:0]  r_rem   [QW];
    logic [QW-1:0]  r_lo    [QW];
    logic [QW-1:0]  r_qb    [QW];

    logic           c_valid [QW];
    logic           c_neg   [QW];
    logic           c_zero  [QW];
    logic           c_ovf   [QW];
    logic [DW-1:0]  c_d     [QW];
    logic [RW-1:0]  c_rem   [QW];
    logic [QW-1:0]  c_lo    [QW];
    logic [QW-1:0]  c_qb    [QW];

    logic [RW:0]    rem_sh  [QW];
    logic           ge      [QW];
    logic [RW-1:0]  n_rem   [QW];

    logic [QW:0]    qmag;
    logic [FW-1:0]  n_q;
    logic           r_o_valid;
    logic [FW-1:0]  r_o_q;

    // magnitude, overflow test and scaled numerator
    assign mag = i_v[VW-1] ? VW'(-i_v) : VW'(i_v);
    assign num = {mag, {FRAC_BITS{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_neg  <= i_v[VW-1];
        r_p_zero <= (i_s == '0);
        r_p_ovf  <= (CW'(mag) >= CW'({i_s, 3'b000}));
        r_p_d    <= {i_s, 1'b0};
        r_p_rem  <= RW'(num[NW-1:QW]);
        r_p_lo   <= num[QW-1:0];
    end

    // stage inputs
    always_comb begin
        c_valid[0] = r_p_valid;
        c_neg[0]   = r_p_neg;
        c_zero[0]  = r_p_zero;
        c_ovf[0]   = r_p_ovf;
        c_d[0]     = r_p_d;
        c_rem[0]   = r_p_rem;
        c_lo[0]    = r_p_lo;
        c_qb[0]    = '0;
        for (int t = 1; t < QW; t++) begin
            c_valid[t] = r_valid[t-1];
            c_neg[t]   = r_neg[t-1];
            c_zero[t]  = r_zero[t-1];
            c_ovf[t]   = r_ovf[t-1];
            c_d[t]     = r_d[t-1];
            c_rem[t]   = r_rem[t-1];
            c_lo[t]    = r_lo[t-1];
            c_qb[t]    = r_qb[t-1];
        end
    end

    // one quotient bit per stage
    always_comb begin
        for (int t = 0; t < QW; t++) begin
            rem_sh[t] = {c_rem[t], c_lo[t][QW-1]};
            ge[t]     = (rem_sh[t] >= (RW + 1)'(c_d[t]));
            n_rem[t]  = ge[t] ? RW'(rem_sh[t] - (RW + 1)'(c_d[t])) : RW'(rem_sh[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < QW; t++) r_valid[t] <= 1'b0;
        end else begin
            for (int t = 0; t < QW; t++) r_valid[t] <= c_valid[t];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int t = 0; t < QW; t++) begin
            r_neg[t]  <= c_neg[t];
            r_zero[t] <= c_zero[t];
            r_ovf[t]  <= c_ovf[t];
            r_d[t]    <= c_d[t];
            r_rem[t]  <= n_rem[t];
            r_lo[t]   <= {c_lo[t][QW-2:0], 1'b0};
            r_qb[t]   <= {c_qb[t][QW-2:0], ge[t]};
        end
    end

    // sign and saturation
    always_comb begin
        qmag = r_ovf[QW-1] ? NEG_LIM << 1 : {1'b0, r_qb[QW-1]};
        if (r_zero[QW-1]) begin
            n_q = '0;
        end else if (!r_neg[QW-1]) begin
            n_q = (qmag > POS_LIM) ? FW'(POS_LIM) : FW'(qmag);
        end else begin
            n_q = (qmag > NEG_LIM) ? FW'(NEG_LIM) : FW'(~qmag + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_valid[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_q <= n_q;
    end

    assign o_valid = r_o_valid;
    assign o_q     = $signed(r_o_q);

endmodule

>>> hw/rtl/rotation_matrix_to_quaternion_unit.sv
// a request once taken shows its quaternion on the result ports for one cycle, marked
// by o_done, after the front, queue, root, divider and result registers
// throughput: one request per cycle; the square root and divider pipelines take a new
// operand every cycle and the result side never stalls, so busy stays low outside reset
// reset: synchronous, active low; clears the valid bits of every stage and the queue
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic signed [FW-1:0] i_row0_col0,
    input  logic signed [FW-1:0] i_row0_col1,
    input  logic signed [FW-1:0] i_row0_col2,
    input  logic signed [FW-1:0] i_row1_col0,
    input  logic signed [FW-1:0] i_row1_col1,
    input  logic signed [FW-1:0] i_row1_col2,
    input  logic signed [FW-1:0] i_row2_col0,
    input  logic signed [FW-1:0] i_row2_col1,
    input  logic signed [FW-1:0] i_row2_col2,
    output logic                 o_done,
    output logic signed [FW-1:0] o_quat_x,
    output logic signed [FW-1:0] o_quat_y,
    output logic signed [FW-1:0] o_quat_z,
    output logic signed [FW-1:0] o_quat_w
);

    localparam int unsigned PIV_W_BITS = $bits(t_pivot);
    localparam int unsigned TAG_W      = PIV_W_BITS + 3 * VW;

    logic [8:0][FW-1:0]   mat;
    logic                 fr_valid;
    t_item                fr_item;
    logic                 q_full;
    logic                 q_valid;
    t_item                q_item;
    logic                 sq_valid;
    logic [SW-1:0]        sq_root;
    logic [TAG_W-1:0]     sq_tag;
    t_pivot               sq_piv;
    logic [2:0][VW-1:0]   sq_lane;
    logic [2:0]           dv_valid;
    logic signed [FW-1:0] dv_q [3];
    t_pivot               r_dl_piv  [DIV_LAT];
    logic [SW-1:0]        r_dl_root [DIV_LAT];
    logic signed [FW-1:0] half;
    logic signed [FW-1:0] n_q [4];
    logic                 r_done;
    logic signed [FW-1:0] r_q [4];

    assign mat = {i_row2_col2, i_row2_col1, i_row2_col0,
                  i_row1_col2, i_row1_col1, i_row1_col0,
                  i_row0_col2, i_row0_col1, i_row0_col0};

    // front: accept and classify
    rmq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_queue_full (q_full),
        .i_mat        (mat),
        .o_busy       (busy),
        .o_valid      (fr_valid),
        .o_item       (fr_item)
    );

    // queue between front and back
    rmq_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .i_pop   (q_valid),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // back: root of the radicand
    rmq_sqrt #(
        .TAG_W (TAG_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_arg   (q_item.arg),
        .i_tag   ({q_item.pivot, q_item.lane}),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_tag   (sq_tag)
    );

    assign sq_piv  = t_pivot'(sq_tag[TAG_W-1 -: PIV_W_BITS]);
    assign sq_lane = sq_tag[3*VW-1:0];

    // back: three quotient lanes
    for (genvar l = 0; l < 3; l++) begin : g_lane
        rmq_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (sq_valid),
            .i_v     ($signed(sq_lane[l])),
            .i_s     (sq_root),
            .o_valid (dv_valid[l]),
            .o_q     (dv_q[l])
        );
    end

    // pivot and root travel alongside the dividers
    always_ff @(posedge i_clk) begin
        r_dl_piv[0]  <= sq_piv;
        r_dl_root[0] <= sq_root;
        for (int i = 1; i < DIV_LAT; i++) begin
            r_dl_piv[i]  <= r_dl_piv[i-1];
            r_dl_root[i] <= r_dl_root[i-1];
        end
    end

    // place the components by pivot
    assign half = $signed(FW'(r_dl_root[DIV_LAT-1] >> 1));

    always_comb begin
        case (r_dl_piv[DIV_LAT-1])
            PIV_X: begin
                n_q[0] = half;    n_q[1] = dv_q[0]; n_q[2] = dv_q[1]; n_q[3] = dv_q[2];
            end
            PIV_Y: begin
                n_q[0] = dv_q[0]; n_q[1] = half;    n_q[2] = dv_q[1]; n_q[3] = dv_q[2];
            end
            PIV_Z: begin
                n_q[0] = dv_q[0]; n_q[1] = dv_q[1]; n_q[2] = half;    n_q[3] = dv_q[2];
            end
            default: begin
                n_q[0] = dv_q[0]; n_q[1] = dv_q[1]; n_q[2] = dv_q[2]; n_q[3] = half;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= &dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) r_q[i] <= n_q[i];
    end

    assign o_done   = r_done;
    assign o_quat_x = r_q[0];
    assign o_quat_y = r_q[1];
    assign o_quat_z = r_q[2];
    assign o_quat_w = r_q[3];

endmodule

>>> hw/rtl/rmq_checker.sv
module rmq_checker import rmq_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done
);

    // every request gives its result after the fixed pipeline depth
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##TOTAL_LAT o_done)
        else $error("request without result at expected cycle");

    // no result without a request that fixed depth earlier
    a_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, TOTAL_LAT))
        else $error("result without matching request");

    // the back never stalls, so the front never refuses
    a_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised outside reset");

    // reset drops the result strobe
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe after reset");

endmodule

bind rotation_matrix_to_quaternion_unit rmq_checker u_rmq_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .o_done  (o_done)
);
